FILE: rtl/core/adad_pkg.sv
// Shared types and constants for the averaging, deadband and display core.
package adad_pkg;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int VALUE_W     = 13;
  localparam int DIGIT_W     = 4;
  localparam int SCALE_W     = 11;
  localparam int DEADBAND_W  = 8;
  localparam int ZTHR_W      = 10;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int DIGIT_IDX_W = 2;

  // Largest converter code
  localparam int SAMPLE_MAX = 4095;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_RANGE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [SCALE_W-1:0]    SCALE_RESET    = 11'd1850;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd10;
  localparam logic [ZTHR_W-1:0]     ZTHR_RESET     = 10'd10;

  // Scaling divides by 1024
  localparam int SCALE_SHIFT = 10;

  // Divide by ten as (x * 52429) >> 19, exact for every 13-bit value
  localparam int DIV10_W     = 16;
  localparam logic [DIV10_W-1:0] DIV10_RECIP = 16'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam int QUOT_W      = 10;

  // Digit step positions
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_ONES     = 2'd0;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_TENS     = 2'd1;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_HUNDREDS = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RING,
    S_MEAN,
    S_SCALE,
    S_HOLD,
    S_DIV,
    S_REM,
    S_DONE
  } state_t;

  // Operand choice for the shared multiplier
  typedef enum logic [1:0] {
    MUL_MEAN,
    MUL_SCALE,
    MUL_DIV10
  } mul_sel_t;

  // Sequencer controls toward the datapath
  typedef struct packed {
    logic                   ready;
    logic                   ring_upd;
    logic                   mul_en;
    mul_sel_t               mul_sel;
    logic                   hold_upd;
    logic                   digit_step;
    logic [DIGIT_IDX_W-1:0] digit_idx;
    logic                   out_load;
  } ctrl_t;

endpackage

FILE: rtl/core/adad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module adad_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/adad_mul.sv
// Shared unsigned multiplier with a registered product.
module adad_mul #(
  parameter int A_W = 17,
  parameter int B_W = 18
) (
  input  logic             clk,
  input  logic             en,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] p
);

  // Register the product of the selected operands
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

endmodule

FILE: rtl/core/adad_ctrl.sv
// Sequencer that steps one sample through the shared multiplier.
module adad_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  output adad_pkg::ctrl_t ctrl
);
  import adad_pkg::*;

  state_t                 state, state_next;
  logic [DIGIT_IDX_W-1:0] digit_idx, digit_idx_next;

  // State and digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      digit_idx <= DIGIT_ONES;
    end else begin
      state     <= state_next;
      digit_idx <= digit_idx_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next      = state;
    digit_idx_next  = digit_idx;
    ctrl            = '0;
    ctrl.mul_sel    = MUL_MEAN;
    ctrl.digit_idx  = digit_idx;
    case (state)
      S_IDLE: begin
        ctrl.ready = 1'b1;
        if (in_valid) begin
          state_next = S_RING;
        end
      end
      S_RING: begin
        ctrl.ring_upd = 1'b1;
        state_next    = S_MEAN;
      end
      S_MEAN: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_MEAN;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SCALE;
        state_next   = S_HOLD;
      end
      S_HOLD: begin
        ctrl.hold_upd  = 1'b1;
        digit_idx_next = DIGIT_ONES;
        state_next     = S_DIV;
      end
      S_DIV: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_DIV10;
        state_next   = S_REM;
      end
      S_REM: begin
        ctrl.digit_step = 1'b1;
        if (digit_idx == DIGIT_HUNDREDS) begin
          state_next = S_DONE;
        end else begin
          digit_idx_next = digit_idx + 1'b1;
          state_next     = S_DIV;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/adad_average_deadband_display_core.sv
// Top level: moving average, scaling, deadband hold and decimal digits.
//
// Input channel: in_valid / in_ready with a 12-bit converter sample per request.
// Output channel: out_valid / out_ready with the display value and its four
// decimal digits, one result per accepted sample.
// Configuration: cfg_write with cfg_index selects scale_range (0), deadband (1)
// or zero_threshold (2); cfg_data carries the value, only the low bits of the
// register's width are kept. Write only while no sample is in flight.
// Flow: a sample enters the ring, then one multiplier is used five times in
// turn (mean by reciprocal, scaling, three divide-by-ten steps). The result is
// loaded into the output register, and the block takes no new sample until
// the last one is through, as its dependent multiplies share the single
// registered multiplier. in_ready is high only while the sequencer idles.
// Reset clears the ring (by a fill flag, no sweep), the running sum, the held
// value, the registers to their defaults and the output valid flag.
// When the receiver stalls, the result waits in the output register; the next
// sample is still taken and is finished up to the output, where it waits.
module adc_average_deadband_display_core #(
  parameter int DEPTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [adad_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [adad_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [adad_pkg::SAMPLE_W-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [adad_pkg::VALUE_W-1:0]        display_value,
  output logic [adad_pkg::DIGIT_W-1:0]        digit_ones,
  output logic [adad_pkg::DIGIT_W-1:0]        digit_tens,
  output logic [adad_pkg::DIGIT_W-1:0]        digit_hundreds,
  output logic [adad_pkg::DIGIT_W-1:0]        digit_thousands
);
  import adad_pkg::*;

  localparam int POS_W       = $clog2(DEPTH);
  localparam int SUM_W       = $clog2(DEPTH * SAMPLE_MAX + 1);
  localparam int RECIP_SHIFT = SUM_W + $clog2(DEPTH);
  localparam int RECIP_W     = SUM_W + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + DEPTH - 1) / DEPTH;
  localparam int MUL_B_W     = (RECIP_W > DIV10_W) ? RECIP_W : DIV10_W;
  localparam int PROD_W      = SUM_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] RECIP = MUL_B_W'(RECIP_FULL);

  ctrl_t ctrl;
  logic  accept;
  logic  out_free;

  // Configuration registers
  logic [SCALE_W-1:0]    scale_range;
  logic [DEADBAND_W-1:0] deadband;
  logic [ZTHR_W-1:0]     zero_threshold;

  // Ring state
  logic [POS_W-1:0]    pos;
  logic                wrapped;
  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] old_sample;

  // Multiplier
  logic [SUM_W-1:0]   mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  // Hold and digit work
  logic [VALUE_W-1:0]  held_value;
  logic [VALUE_W-1:0]  held_next;
  logic [VALUE_W-1:0]  scaled;
  logic [VALUE_W-1:0]  disp;
  logic [VALUE_W-1:0]  disp_r;
  logic [VALUE_W-1:0]  work;
  logic [QUOT_W-1:0]   quot;
  logic [VALUE_W-1:0]  quot_x10;
  logic [DIGIT_W-1:0]  digit;
  logic [DIGIT_W-1:0]  ones_r, tens_r, hundreds_r, thousands_r;
  logic [VALUE_W:0]    hold_low, hold_high;

  assign accept   = in_valid && ctrl.ready;
  assign in_ready = ctrl.ready;
  assign out_free = !out_valid || out_ready;

  adad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_range    <= SCALE_RESET;
      deadband       <= DEADBAND_RESET;
      zero_threshold <= ZTHR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCALE_RANGE:    scale_range    <= cfg_data[SCALE_W-1:0];
        REG_DEADBAND:       deadband       <= cfg_data[DEADBAND_W-1:0];
        REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[ZTHR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample ring
  adad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.ring_upd),
    .waddr (pos),
    .wdata (sample_r),
    .re    (accept),
    .raddr (pos),
    .rdata (ring_rdata)
  );

  // Slots not yet written on the first lap read as zero
  assign old_sample = wrapped ? ring_rdata : '0;

  // Capture the sample on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
    end
  end

  // Update running sum and ring position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      wrapped    <= 1'b0;
      window_sum <= '0;
    end else if (ctrl.ring_upd) begin
      window_sum <= window_sum - SUM_W'(old_sample) + SUM_W'(sample_r);
      if (pos == POS_W'(DEPTH - 1)) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctrl.mul_sel)
      MUL_MEAN: begin
        mul_a = window_sum;
        mul_b = RECIP;
      end
      MUL_SCALE: begin
        mul_a = SUM_W'(prod[RECIP_SHIFT +: SAMPLE_W]);
        mul_b = MUL_B_W'(scale_range);
      end
      MUL_DIV10: begin
        mul_a = SUM_W'(work);
        mul_b = MUL_B_W'(DIV10_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  adad_mul #(
    .A_W (SUM_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Deadband: move only when more than deadband away in either direction
  assign scaled    = prod[SCALE_SHIFT +: VALUE_W];
  assign hold_low  = {1'b0, held_value} + (VALUE_W+1)'(deadband);
  assign hold_high = {1'b0, scaled} + (VALUE_W+1)'(deadband);
  assign held_next = ((hold_low < {1'b0, scaled}) || ({1'b0, held_value} > hold_high))
                     ? scaled : held_value;
  assign disp      = (scaled > VALUE_W'(zero_threshold)) ? held_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value <= '0;
    end else if (ctrl.hold_upd) begin
      held_value <= held_next;
    end
  end

  // Peel off one decimal digit per step
  assign quot     = prod[DIV10_SHIFT +: QUOT_W];
  assign quot_x10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
  assign digit    = DIGIT_W'(work - quot_x10);

  always_ff @(posedge clk) begin
    if (ctrl.hold_upd) begin
      disp_r <= disp;
      work   <= disp;
    end else if (ctrl.digit_step) begin
      work <= VALUE_W'(quot);
      case (ctrl.digit_idx)
        DIGIT_ONES: ones_r <= digit;
        DIGIT_TENS: tens_r <= digit;
        DIGIT_HUNDREDS: begin
          hundreds_r  <= digit;
          thousands_r <= DIGIT_W'(quot);
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      display_value   <= disp_r;
      digit_ones      <= ones_r;
      digit_tens      <= tens_r;
      digit_hundreds  <= hundreds_r;
      digit_thousands <= thousands_r;
    end
  end

endmodule

FILE: rtl/core/adad_checker.sv
// Port-level checks for the averaging, deadband and display core.
module adad_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [adad_pkg::VALUE_W-1:0]     display_value,
  input logic [adad_pkg::DIGIT_W-1:0]     digit_ones,
  input logic [adad_pkg::DIGIT_W-1:0]     digit_tens,
  input logic [adad_pkg::DIGIT_W-1:0]     digit_hundreds,
  input logic [adad_pkg::DIGIT_W-1:0]     digit_thousands
);
  import adad_pkg::*;

  localparam int SUM_CHK_W = VALUE_W + 4;

  localparam logic [SUM_CHK_W-1:0] W_THOUSANDS = SUM_CHK_W'(1000);
  localparam logic [SUM_CHK_W-1:0] W_HUNDREDS  = SUM_CHK_W'(100);
  localparam logic [SUM_CHK_W-1:0] W_TENS      = SUM_CHK_W'(10);
  localparam logic [DIGIT_W-1:0]   DIGIT_MAX   = DIGIT_W'(9);

  logic [SUM_CHK_W-1:0] digit_sum;

  assign digit_sum = SUM_CHK_W'(digit_thousands) * W_THOUSANDS +
                     SUM_CHK_W'(digit_hundreds) * W_HUNDREDS +
                     SUM_CHK_W'(digit_tens) * W_TENS +
                     SUM_CHK_W'(digit_ones);

  // Digits spell out the shown value
  a_digits_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_sum == SUM_CHK_W'(display_value)) &&
                  (digit_ones <= DIGIT_MAX) && (digit_tens <= DIGIT_MAX) &&
                  (digit_hundreds <= DIGIT_MAX))
    else $error("digits do not match display value");

  // One sample at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready did not drop after accepting a sample");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(display_value))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind adc_average_deadband_display_core adad_checker u_adad_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .display_value   (display_value),
  .digit_ones      (digit_ones),
  .digit_tens      (digit_tens),
  .digit_hundreds  (digit_hundreds),
  .digit_thousands (digit_thousands)
);

FILE: tb/adc_average_deadband_display_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the moving-average, deadband and decimal display core.
module adc_average_deadband_display_core_tb;
  import adad_pkg::*;

  localparam int DEPTH        = 20;
  localparam int NUM_ROWS     = 29;
  localparam int NUM_PHASES   = 13;
  localparam int PHASE_ITEMS  = 100;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FROM_MODEL   = -1;

  // Index past the last register, which the block must ignore
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {MODE_UNIFORM, MODE_STEADY, MODE_EXTREME, MODE_RAMP} sample_mode_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]    data;
    logic [SAMPLE_W-1:0]      value;
    int                       typed;
  } stim_row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0] ones;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] thousands;
  } reading_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [VALUE_W-1:0]     display_value;
  logic [DIGIT_W-1:0]     digit_ones;
  logic [DIGIT_W-1:0]     digit_tens;
  logic [DIGIT_W-1:0]     digit_hundreds;
  logic [DIGIT_W-1:0]     digit_thousands;

  // Predictor state and register copies
  logic [SAMPLE_W-1:0]   window_ring [DEPTH];
  int                    ring_pos;
  logic [VALUE_W-1:0]    held_reading;
  logic [SCALE_W-1:0]    cfg_scale;
  logic [DEADBAND_W-1:0] cfg_band;
  logic [ZTHR_W-1:0]     cfg_floor;

  reading_t pending_readings[$];
  int       mismatches;
  int       samples_sent;
  int       results_checked;
  int       reg_writes;
  bit       idle_on;
  bit       hold_request;

  // Directed stimulus: typed expectations only where obvious
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd0,     0},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'hAAA,   FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'h555,   FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd1,     FROM_MODEL},
    '{ROW_WRITE,  REG_SCALE_RANGE,    11'd0,     12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  0},
    '{ROW_WRITE,  REG_SCALE_RANGE,    11'd2047,  12'd0,     FROM_MODEL},
    '{ROW_WRITE,  REG_DEADBAND,       11'd0,     12'd0,     FROM_MODEL},
    '{ROW_WRITE,  REG_ZERO_THRESHOLD, 11'd0,     12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd0,     FROM_MODEL},
    '{ROW_WRITE,  REG_DEADBAND,       11'h7FF,   12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd2048,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd2047,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_WRITE,  REG_ZERO_THRESHOLD, 11'h7FF,   12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_WRITE,  REG_UNUSED,         11'h7FF,   12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd100,   FROM_MODEL},
    '{ROW_WRITE,  REG_SCALE_RANGE,    11'd1,     12'd0,     FROM_MODEL},
    '{ROW_WRITE,  REG_DEADBAND,       11'd0,     12'd0,     FROM_MODEL},
    '{ROW_WRITE,  REG_ZERO_THRESHOLD, 11'd0,     12'd0,     FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL},
    '{ROW_SAMPLE, REG_SCALE_RANGE,    11'd0,     12'd4095,  FROM_MODEL}
  };

  adc_average_deadband_display_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .display_value  (display_value),
    .digit_ones     (digit_ones),
    .digit_tens     (digit_tens),
    .digit_hundreds (digit_hundreds),
    .digit_thousands(digit_thousands)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Split a display value into its decimal digits
  function automatic reading_t split_digits(input logic [VALUE_W-1:0] v);
    reading_t r;
    r.value     = v;
    r.ones      = DIGIT_W'(v % 10);
    r.tens      = DIGIT_W'((v / 10) % 10);
    r.hundreds  = DIGIT_W'((v / 100) % 10);
    r.thousands = DIGIT_W'((v / 1000) % 10);
    return r;
  endfunction

  // Take one sample into the ring, average, scale, apply deadband and zero floor
  function automatic reading_t advance_average(input logic [SAMPLE_W-1:0] s);
    logic [16:0] total;
    int unsigned mean;
    int unsigned scaled;
    int          sv;
    int          hv;
    int          dv;
    int          i;
    window_ring[ring_pos] = s;
    ring_pos = (ring_pos >= DEPTH - 1) ? 0 : ring_pos + 1;
    total = '0;
    for (i = 0; i < DEPTH; i++) total += window_ring[i];
    mean   = total / DEPTH;
    scaled = (mean * cfg_scale) >> SCALE_SHIFT;
    // Signed comparisons: scaled - deadband may go negative near zero
    sv = int'(scaled);
    dv = int'(cfg_band);
    hv = int'(held_reading);
    if (hv < sv - dv) held_reading = VALUE_W'(scaled);
    hv = int'(held_reading);
    if (hv > sv + dv) held_reading = VALUE_W'(scaled);
    return split_digits((scaled > cfg_floor) ? held_reading : '0);
  endfunction

  // Wait until every expected reading has come back
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle, and mirror it in the predictor
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    drain_readings();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SCALE_RANGE:    cfg_scale = data[SCALE_W-1:0];
      REG_DEADBAND:       cfg_band  = data[DEADBAND_W-1:0];
      REG_ZERO_THRESHOLD: cfg_floor = data[ZTHR_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Offer one sample request and queue its expected reading once accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int typed);
    reading_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    want = advance_average(s);
    if (typed != FROM_MODEL) want = split_digits(VALUE_W'(typed));
    pending_readings.push_back(want);
    samples_sent++;
  endtask

  // Compare one accepted reading with the oldest expectation
  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      $error("unexpected reading: display_value %0d", display_value);
      mismatches++;
    end else begin
      want = pending_readings.pop_front();
      results_checked++;
      if (display_value !== want.value) begin
        $error("display_value: expected %0d, got %0d", want.value, display_value);
        mismatches++;
      end
      if (digit_ones !== want.ones) begin
        $error("digit_ones: expected %0d, got %0d", want.ones, digit_ones);
        mismatches++;
      end
      if (digit_tens !== want.tens) begin
        $error("digit_tens: expected %0d, got %0d", want.tens, digit_tens);
        mismatches++;
      end
      if (digit_hundreds !== want.hundreds) begin
        $error("digit_hundreds: expected %0d, got %0d", want.hundreds, digit_hundreds);
        mismatches++;
      end
      if (digit_thousands !== want.thousands) begin
        $error("digit_thousands: expected %0d, got %0d", want.thousands, digit_thousands);
        mismatches++;
      end
    end
  endtask

  // Receiver: check readings, stall in random bursts and once for a long stretch
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_reading();
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t          row;
    sample_mode_t       mode;
    logic [CFG_DATA_W-1:0] pick;
    int                 level;
    int                 stride;
    int                 v;
    int                 r;
    int                 p;
    int                 k;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample    <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_SCALE_RANGE;
    cfg_data  <= '0;
    mismatches      = 0;
    samples_sent    = 0;
    results_checked = 0;
    reg_writes      = 0;
    idle_on         = 1'b1;
    hold_request    = 1'b0;

    // Predictor reset state
    foreach (window_ring[i]) window_ring[i] = '0;
    ring_pos     = 0;
    held_reading = '0;
    cfg_scale    = SCALE_RESET;
    cfg_band     = DEADBAND_RESET;
    cfg_floor    = ZTHR_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) write_register(row.index, row.data);
      else send_sample(row.value, row.typed);
    end

    // Random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       pick = 11'd0;
        1:       pick = 11'd1;
        2:       pick = 11'd2047;
        3:       pick = CFG_DATA_W'(SCALE_RESET);
        default: pick = CFG_DATA_W'($urandom_range(1, 2047));
      endcase
      write_register(REG_SCALE_RANGE, pick);
      case ($urandom_range(0, 3))
        0:       pick = 11'd0;
        1:       pick = 11'd255;
        default: pick = CFG_DATA_W'($urandom_range(0, 2047));
      endcase
      write_register(REG_DEADBAND, pick);
      case ($urandom_range(0, 4))
        0:       pick = 11'd0;
        1:       pick = 11'h7FF;
        2:       pick = CFG_DATA_W'(ZTHR_RESET);
        default: pick = CFG_DATA_W'($urandom_range(0, 2047));
      endcase
      write_register(REG_ZERO_THRESHOLD, pick);
      if ($urandom_range(0, 1) == 1)
        write_register(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));

      idle_on = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      if (p == 2) hold_request = 1'b1;
      mode   = sample_mode_t'($urandom_range(0, 3));
      level  = $urandom_range(0, SAMPLE_MAX);
      stride = $urandom_range(1, 200);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        case (mode)
          MODE_STEADY: begin
            // Hover around a level so the deadband is exercised
            if ($urandom_range(0, 15) == 0) level = $urandom_range(0, SAMPLE_MAX);
            v = level + int'($urandom_range(0, 30)) - 15;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          end
          MODE_EXTREME: begin
            if ($urandom_range(0, 7) == 0) v = $urandom_range(0, SAMPLE_MAX);
            else v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
          end
          MODE_RAMP: begin
            level = (level + stride) % (SAMPLE_MAX + 1);
            v = level;
          end
          default: v = $urandom_range(0, SAMPLE_MAX);
        endcase
        send_sample(SAMPLE_W'(v), FROM_MODEL);
      end
    end

    // Drain and let the pipeline settle
    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples over %0d register writes, %0d readings checked.",
             samples_sent, reg_writes, results_checked);
    $display("Settings spanned zero and full scale, deadband 0 to 255, threshold 0 to 1023.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/adad_pkg.sv
rtl/core/adad_ram.sv
rtl/core/adad_mul.sv
rtl/core/adad_ctrl.sv
rtl/core/adad_average_deadband_display_core.sv
rtl/core/adad_checker.sv
tb/adc_average_deadband_display_core_tb.sv
